@@ sv/mexp_pkg.sv @@
package mexp_pkg;

  localparam int BASE_BITS = 31;
  localparam int EXP_FIELD_BITS = 63;
  localparam int STEP_CNT_W = $clog2(BASE_BITS);
  localparam logic [30:0] MOD_RESET = 31'd1000000007;

endpackage

@@ sv/mexp_mulmod.sv @@
module mexp_mulmod import mexp_pkg::*; #(
  parameter int W = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [W-1:0]         x_i,
  input  logic [BASE_BITS-1:0] y_i,
  input  logic [W-1:0]         m_i,
  output logic                 done_o,
  output logic [W-1:0]         p_o
);

  logic                  busy_q;
  logic [STEP_CNT_W-1:0] cnt_q;
  logic [W-1:0]          acc_q, acc_d;
  logic [W-1:0]          x_q, m_q;
  logic [BASE_BITS-1:0]  y_q;
  logic [W+1:0]          sum, m1, m2, red;

  // One multiplier bit per cycle, most significant first, with the partial
  // sum kept below the modulus by one subtraction of either the modulus or twice it.
  always_comb begin
    m1  = {2'b00, m_q};
    m2  = {1'b0, m_q, 1'b0};
    sum = {1'b0, acc_q, 1'b0} + (y_q[BASE_BITS-1] ? {2'b00, x_q} : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
    acc_d = red[W-1:0];
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign p_o    = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= STEP_CNT_W'(BASE_BITS - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      y_q   <= y_i;
      m_q   <= m_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[BASE_BITS-2:0], 1'b0};
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier restarted while busy");
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (m_q >= W'(2)) |-> acc_d < m_q)
    else $error("partial sum left the residue range");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !start_i |=> !busy_q)
    else $error("multiplier kept running after its last step");
`endif

endmodule

@@ sv/modular_exponentiation_unit.sv @@
// Modular exponentiation unit: power = base ^ exponent mod modulus.
// Input requests arrive on the s_axis channel, results leave on m_axis;
// a request moves when tvalid and tready are both high.
// The user must set the modulus through cfg_we_i / cfg_wdata_i only while
// the unit is idle; the unit itself does not enforce it. The base is first
// reduced by one bit-serial modular multiply, then the exponent is scanned
// from its lowest bit; each bit runs a square and a conditional multiply
// side by side in two bit-serial multipliers. A modular multiply steps
// through the 31 multiplier bits. The exponent scan stops after its highest
// set bit (at most EXP_BITS bits); an exponent of zero skips the scan, and
// a modulus below two skips all multiplies and gives zero.
// The next request is taken in the cycle the result is presented, even if
// the receiver has not taken it yet; requests are handled one at a time.
// If the receiver stalls, the result is held and a finished second result
// waits until the output register is free.
// Reset clears all requests in flight and sets the modulus to 1000000007.
module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int EXP_BITS = 63,
  parameter int MOD_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,   // modulus
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i, // base [30:0], exponent [93:31]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o  // power [30:0]
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOOP,
    ST_FINISH
  } state_e;

  state_e                state_q;
  logic [MOD_BITS-1:0]   mod_q, b_q, r_q, res_q;
  logic [EXP_BITS-1:0]   e_q;
  logic                  start_q, start_d;
  logic                  out_valid_q;
  logic [30:0]           out_power_q;
  logic                  in_req;
  logic                  a_done, b_done;
  logic [MOD_BITS-1:0]   a_p, b_p;
  logic [MOD_BITS-1:0]   a_x;
  logic [BASE_BITS-1:0]  a_y;
  logic [30:0]           in_base;
  logic [30:0]           in_base_q;
  logic [EXP_BITS-1:0]   in_exp;
  logic [EXP_BITS-1:0]   e_next;

  assign in_base = s_axis_tdata_i[30:0];
  assign in_exp  = s_axis_tdata_i[31 +: EXP_BITS];
  assign e_next  = e_q >> 1;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_req          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_power_q};

  assign start_d = (in_req && (mod_q >= MOD_BITS'(2)))
                || ((state_q == ST_REDUCE) && a_done && (e_q != '0))
                || ((state_q == ST_LOOP) && a_done && (e_next != '0));

  // Unit A reduces the base first, then forms the running product.
  assign a_x = (state_q == ST_REDUCE) ? MOD_BITS'(1) : r_q;
  assign a_y = (state_q == ST_REDUCE) ? BASE_BITS'(in_base_q) : BASE_BITS'(b_q);

  mexp_mulmod #(.W(MOD_BITS)) u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .x_i     (a_x),
    .y_i     (a_y),
    .m_i     (mod_q),
    .done_o  (a_done),
    .p_o     (a_p)
  );

  mexp_mulmod #(.W(MOD_BITS)) u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q && (state_q == ST_LOOP)),
    .x_i     (b_q),
    .y_i     (BASE_BITS'(b_q)),
    .m_i     (mod_q),
    .done_o  (b_done),
    .p_o     (b_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_RESET[MOD_BITS-1:0];
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_power_q <= '0;
      in_base_q   <= '0;
      e_q         <= '0;
      b_q         <= '0;
      r_q         <= '0;
      res_q       <= '0;
    end else begin
      start_q <= start_d;
      if ((state_q == ST_FINISH) && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_req) begin
            in_base_q <= in_base;
            e_q       <= in_exp;
            if (mod_q < MOD_BITS'(2)) begin
              res_q   <= '0;
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (a_done) begin
            b_q <= a_p;
            r_q <= MOD_BITS'(1);
            if (e_q == '0) begin
              res_q   <= MOD_BITS'(1);
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_LOOP;
            end
          end
        end
        ST_LOOP: begin
          if (a_done) begin
            b_q <= b_p;
            e_q <= e_next;
            if (e_q[0]) begin
              r_q <= a_p;
            end
            if (e_next == '0) begin
              res_q   <= e_q[0] ? a_p : r_q;
              state_q <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_power_q <= 31'(res_q);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_units_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOP) |-> (a_done == b_done))
    else $error("square and multiply units out of step");
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && (mod_q >= MOD_BITS'(2)) |-> res_q < mod_q)
    else $error("result not reduced by the modulus");
  a_loop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOP) |-> (r_q < mod_q) && (b_q < mod_q))
    else $error("running values left the residue range");
  a_loop_nonzero_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOP) |-> (e_q != '0))
    else $error("exponent scan kept running on an empty exponent");
`endif

endmodule

@@ dv/modular_exponentiation_unit_checker.sv @@
`timescale 1ns / 100ps

module modular_exponentiation_unit_checker import mexp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [95:0] req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [31:0] rsp_data_i,
  output int          mismatches_o,
  output int          outstanding_o,
  output int          results_o
);

  logic [30:0] modulus_q;
  logic [30:0] pending_powers[$];
  logic [30:0] expected_power;
  int          mismatch_count = 0;
  int          result_count = 0;

  assign mismatches_o = mismatch_count;
  assign results_o    = result_count;

  function automatic logic [30:0] predict_power(logic [30:0] base, logic [62:0] exponent,
                                                logic [30:0] modulus);
    logic [63:0] m;
    logic [63:0] square;
    logic [63:0] acc;
    m = 64'(modulus);
    if (m < 64'd2) return '0;
    square = 64'(base) % m;
    acc = 64'd1;
    for (int i = 0; i < EXP_FIELD_BITS; i++) begin
      if (exponent[i]) acc = (acc * square) % m;
      square = (square * square) % m;
    end
    return acc[30:0];
  endfunction

  task automatic report_mismatch(string what, logic [30:0] expected_v, logic [30:0] got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, expected_v, got_v);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_RESET;
      pending_powers.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
      if (rsp_valid_i && rsp_ready_i) begin
        result_count++;
        if (pending_powers.size() == 0) begin
          report_mismatch("result with no request waiting", '0, rsp_data_i[30:0]);
        end else begin
          expected_power = pending_powers.pop_front();
          if (rsp_data_i[30:0] !== expected_power) begin
            report_mismatch("power", expected_power, rsp_data_i[30:0]);
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        pending_powers = {pending_powers,
                          predict_power(req_data_i[30:0], req_data_i[93:31], modulus_q)};
      end
      outstanding_o <= pending_powers.size();
    end
  end

endmodule

@@ dv/modular_exponentiation_unit_tb.sv @@
`timescale 1ns / 100ps

module modular_exponentiation_unit_tb import mexp_pkg::*;;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int RANDOM_PER_PHASE = 166;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [30:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  int          mismatches;
  int          outstanding;
  int          results;
  int          cycle_count = 0;
  int          sent = 0;
  int          directed = 0;
  int          settings = 1;
  int          stall_left = 0;
  bit          quiet = 1'b0;
  logic [30:0] modulus_now = MOD_RESET;

  modular_exponentiation_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  modular_exponentiation_unit_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .results_o    (results)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  function automatic logic [62:0] random_exponent();
    logic [63:0] raw;
    int          r;
    int          len;
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 7) return raw[62:0];
    if (r < 20) len = $urandom_range(13, 24);
    else len = $urandom_range(1, 12);
    return raw[62:0] & ((63'd1 << len) - 63'd1);
  endfunction

  function automatic logic [30:0] random_base(logic [30:0] modulus);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 31'd1;
      2: return modulus - 31'd1;
      3: return modulus;
      4: return modulus + 31'd1;
      5: return '1;
      6, 7: return 31'($urandom);
      default: return (modulus == '0) ? 31'($urandom) : 31'($urandom % modulus);
    endcase
  endfunction

  task automatic send_request(logic [30:0] base, logic [62:0] exponent);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, exponent, base};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_modulus(logic [30:0] value);
    wait_idle();
    repeat (40) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    modulus_now = value;
    settings++;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      send_request(random_base(modulus_now), random_exponent());
      if ($urandom_range(0, 99) == 0) wait_idle();
    end
  endtask

  initial begin
    logic [30:0] phase_moduli[10];
    phase_moduli = '{31'h7FFF_FFFF, 31'd2, 31'd3, 31'd0, 31'd1, 31'd65537, 31'h4000_0000,
                     31'h7FFF_FFFE, 31'($urandom_range(2, 32'h7FFF_FFFF)), 31'd97};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request('0, '0);
    send_request('0, 63'd1);
    send_request('0, '1);
    send_request(31'd1, '0);
    send_request('1, '0);
    send_request('1, '1);
    send_request('1, 63'd1);
    send_request(31'd2, 63'h4000_0000_0000_0000);
    send_request(31'd1000000006, 63'd2);
    send_request(31'd1000000007, 63'd5);
    send_request(31'd1000000008, 63'd7);
    send_request(31'd2, 63'd1000000006);
    send_request(31'd3, 63'd1000000005);
    send_request(31'd12345, 63'h1_0000_0000);
    send_request(31'h2AAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA);
    send_request(31'h5555_5555, 63'h5555_5555_5555_5555);
    directed = sent;

    run_random(RANDOM_PER_PHASE);
    foreach (phase_moduli[p]) begin
      write_modulus(phase_moduli[p]);
      quiet = (p == 2 || p == 6);
      run_random(RANDOM_PER_PHASE);
    end
    quiet = 1'b0;

    wait_idle();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d requests (%0d directed) under %0d modulus settings; %0d results compared.",
             sent, directed, settings, results);
    $display("Moduli spanned 0, 1, 2 up to 2^31-1, exponents up to the full 63 bits.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
